FILE: src/lcgsh_pkg.sv
// Package for the combined LCG random unit with shuffle table.
// Holds generator constants, the controller state type and command/status structs.
// No dependencies.
package lcgsh_pkg;

  localparam logic [30:0] MOD_A       = 31'd2147483563;
  localparam logic [30:0] MOD_B       = 31'd2147483399;
  localparam logic [15:0] MUL_A       = 16'd40014;
  localparam logic [15:0] MUL_B       = 16'd40692;
  localparam logic [15:0] QUO_A       = 16'd53668;
  localparam logic [15:0] QUO_B       = 16'd52774;
  localparam logic [13:0] REM_A       = 14'd12211;
  localparam logic [13:0] REM_B       = 14'd3791;
  localparam logic [30:0] GEN_B_RESET = 31'd123456789;
  localparam logic [30:0] WRAP_TOP    = 31'd2147483562;
  localparam logic [30:0] SEED_RESET  = 31'd1;

  // Reciprocals scaled by 2^47; the quotient estimate is exact or one low.
  localparam int unsigned RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP_A = 32'((64'd1 << RECIP_SHIFT) / 64'd53668);
  localparam logic [31:0] RECIP_B = 32'((64'd1 << RECIP_SHIFT) / 64'd52774);

  typedef enum logic {
    GEN_A,
    GEN_B
  } gen_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_LOAD,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_DRAW_READ,
    ST_DRAW_WAIT,
    ST_DRAW_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic     seed_load;
    logic     step_go;
    gen_sel_e step_sel;
    logic     seed_wr;
    logic     last_ld;
    logic     rd_en;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic     res_valid;
    gen_sel_e res_sel;
  } sts_t;

endpackage

FILE: src/lcgsh_if.sv
// Channel interfaces of the combined LCG random unit: request, result and seed write.
// Depends on nothing.
interface lcgsh_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink (input valid, input reseed, output ready);
endinterface

interface lcgsh_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface lcgsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lcgsh_schrage.sv
// Pipelined Schrage step x -> (mul * x) mod m for either generator.
// Depends on lcgsh_pkg for the generator constants and the select type.
module lcgsh_schrage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  lcgsh_pkg::gen_sel_e sel_i,
  input  logic [30:0]        x_i,
  output logic               res_valid_o,
  output lcgsh_pkg::gen_sel_e res_sel_o,
  output logic [30:0]        res_o
);

  logic [3:0]          vld_q, vld_d;
  lcgsh_pkg::gen_sel_e sel_q [4];

  logic [30:0] x1_q;
  logic [62:0] p1_q, p1_d;
  logic [31:0] recip;

  logic [15:0] hi0;
  logic [15:0] quo2;
  logic [31:0] lo0_full;
  logic [16:0] lo2_q;
  logic [15:0] hi2_q;

  logic [15:0] quo3;
  logic [15:0] lo3_q, lo3_d;
  logic [15:0] hi3_q, hi3_d;

  logic [15:0] mul4;
  logic [13:0] rem4;
  logic [31:0] pm4_q, pr4_q;

  logic [30:0]        mod5;
  logic signed [32:0] diff;
  logic signed [32:0] wrapped;

  assign recip = (sel_i == lcgsh_pkg::GEN_A) ? lcgsh_pkg::RECIP_A : lcgsh_pkg::RECIP_B;
  assign p1_d  = 63'(x_i) * 63'(recip);

  assign hi0      = p1_q[62:47];
  assign quo2     = (sel_q[0] == lcgsh_pkg::GEN_A) ? lcgsh_pkg::QUO_A : lcgsh_pkg::QUO_B;
  assign lo0_full = {1'b0, x1_q} - (32'(hi0) * 32'(quo2));

  assign quo3 = (sel_q[1] == lcgsh_pkg::GEN_A) ? lcgsh_pkg::QUO_A : lcgsh_pkg::QUO_B;

  always_comb begin
    if (lo2_q >= 17'(quo3)) begin
      lo3_d = 16'(lo2_q - 17'(quo3));
      hi3_d = hi2_q + 16'd1;
    end else begin
      lo3_d = lo2_q[15:0];
      hi3_d = hi2_q;
    end
  end

  assign mul4 = (sel_q[2] == lcgsh_pkg::GEN_A) ? lcgsh_pkg::MUL_A : lcgsh_pkg::MUL_B;
  assign rem4 = (sel_q[2] == lcgsh_pkg::GEN_A) ? lcgsh_pkg::REM_A : lcgsh_pkg::REM_B;

  assign mod5    = (sel_q[3] == lcgsh_pkg::GEN_A) ? lcgsh_pkg::MOD_A : lcgsh_pkg::MOD_B;
  assign diff    = signed'({1'b0, pm4_q}) - signed'({1'b0, pr4_q});
  assign wrapped = (diff < 0) ? (diff + signed'(33'(mod5))) : diff;

  assign vld_d = {vld_q[2:0], go_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q[0] <= sel_i;
    sel_q[1] <= sel_q[0];
    sel_q[2] <= sel_q[1];
    sel_q[3] <= sel_q[2];
    x1_q     <= x_i;
    p1_q     <= p1_d;
    lo2_q    <= lo0_full[16:0];
    hi2_q    <= hi0;
    lo3_q    <= lo3_d;
    hi3_q    <= hi3_d;
    pm4_q    <= 32'(mul4) * 32'(lo3_q);
    pr4_q    <= 32'(hi3_q) * 32'(rem4);
  end

  assign res_valid_o = vld_q[3];
  assign res_sel_o   = sel_q[3];
  assign res_o       = wrapped[30:0];

endmodule

FILE: src/lcgsh_datapath.sv
// Datapath: seed register, both generators, shuffle table memory, index and output logic.
// Depends on lcgsh_pkg and instantiates lcgsh_schrage.
module lcgsh_datapath #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [30:0]                   cfg_data_i,
  input  lcgsh_pkg::cmd_t               cmd_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] seed_idx_i,
  output lcgsh_pkg::sts_t               sts_o,
  output logic [30:0]                   value_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_SIZE);
  localparam int unsigned RW     = IdxW + 2;
  localparam int unsigned IdxDiv = 1 + (2147483562 / TABLE_SIZE);
  localparam logic [RW-1:0] IdxRecip = RW'((64'd1 << 31) / 64'(IdxDiv));

  logic [30:0] seed_q;
  logic [30:0] gen_a_q, gen_b_q;
  logic [30:0] last_out_q;
  logic [30:0] value_q;
  logic [30:0] seed_eff;

  logic                step_valid;
  lcgsh_pkg::gen_sel_e step_sel;
  logic [30:0]         step_res;
  logic [30:0]         step_x;

  logic [31+RW-1:0] idx_prod;
  logic [RW-1:0]    q0_q;
  logic [31:0]      idx_rem;
  logic [RW-1:0]    q1;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [30:0] tbl_mem_q [TABLE_SIZE];
  logic [30:0] rd_data_q;
  logic             tbl_we;
  logic [IdxW-1:0]  tbl_wa;
  logic [30:0]      tbl_wd;

  logic signed [31:0] diff;
  logic [30:0]        y;

  assign seed_eff = (seed_q == '0) ? 31'd1 : seed_q;
  assign step_x   = (cmd_i.step_sel == lcgsh_pkg::GEN_A) ? gen_a_q : gen_b_q;

  lcgsh_schrage u_schrage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (cmd_i.step_go),
    .sel_i       (cmd_i.step_sel),
    .x_i         (step_x),
    .res_valid_o (step_valid),
    .res_sel_o   (step_sel),
    .res_o       (step_res)
  );

  assign sts_o.res_valid = step_valid;
  assign sts_o.res_sel   = step_sel;

  // Table index: reciprocal estimate, then a single correction and a clamp.
  assign idx_prod = (31 + RW)'(last_out_q) * (31 + RW)'(IdxRecip);
  assign idx_rem  = {1'b0, last_out_q} - (32'(q0_q) * 32'(IdxDiv));
  assign q1       = (idx_rem >= 32'(IdxDiv)) ? (q0_q + RW'(1)) : q0_q;
  assign idx_d    = (q1 >= RW'(TABLE_SIZE)) ? IdxW'(TABLE_SIZE - 1) : IdxW'(q1);

  assign diff = signed'({1'b0, rd_data_q}) - signed'({1'b0, gen_b_q});
  assign y    = (diff < 32'sd1) ? 31'(diff + signed'(32'(lcgsh_pkg::WRAP_TOP)))
                                : diff[30:0];

  assign tbl_we = cmd_i.seed_wr || cmd_i.fin;
  assign tbl_wa = cmd_i.fin ? idx_q : seed_idx_i;
  assign tbl_wd = cmd_i.fin ? gen_a_q : step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= lcgsh_pkg::SEED_RESET;
      gen_a_q    <= '0;
      gen_b_q    <= lcgsh_pkg::GEN_B_RESET;
      last_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.seed_load) begin
        gen_a_q <= seed_eff;
        gen_b_q <= seed_eff;
      end else if (step_valid) begin
        if (step_sel == lcgsh_pkg::GEN_A) begin
          gen_a_q <= step_res;
        end else begin
          gen_b_q <= step_res;
        end
      end
      if (cmd_i.fin) begin
        last_out_q <= y;
      end else if (cmd_i.seed_wr && cmd_i.last_ld) begin
        last_out_q <= step_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q  <= idx_prod[31+RW-1:31];
    idx_q <= idx_d;
    if (cmd_i.fin) begin
      value_q <= y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem_q[tbl_wa] <= tbl_wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= tbl_mem_q[idx_q];
    end
  end

  assign value_o = value_q;

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (y != '0 && y <= lcgsh_pkg::WRAP_TOP))
    else $error("Drawn word outside 1..WRAP_TOP.");

endmodule

FILE: src/lcgsh_ctrl.sv
// Controller state machine: sequences seeding, the two generator steps and the draw.
// Depends on lcgsh_pkg for the state type and the command/status structs.
module lcgsh_ctrl #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          reseed_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  input  lcgsh_pkg::sts_t               sts_i,
  output lcgsh_pkg::cmd_t               cmd_o,
  output logic [$clog2(TABLE_SIZE)-1:0] seed_idx_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);
  localparam int unsigned CntW = $clog2(TABLE_SIZE + 8);

  lcgsh_pkg::ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            seeded_q, seeded_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcgsh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (reseed_i || !seeded_q) ? lcgsh_pkg::ST_SEED_LOAD : lcgsh_pkg::ST_DRAW_A;
        end
      end
      lcgsh_pkg::ST_SEED_LOAD:  state_d = lcgsh_pkg::ST_SEED_ISSUE;
      lcgsh_pkg::ST_SEED_ISSUE: state_d = lcgsh_pkg::ST_SEED_WAIT;
      lcgsh_pkg::ST_SEED_WAIT: begin
        if (sts_i.res_valid) begin
          state_d = (cnt_q == '0) ? lcgsh_pkg::ST_DRAW_A : lcgsh_pkg::ST_SEED_ISSUE;
        end
      end
      lcgsh_pkg::ST_DRAW_A:    state_d = lcgsh_pkg::ST_DRAW_B;
      lcgsh_pkg::ST_DRAW_B:    state_d = lcgsh_pkg::ST_DRAW_READ;
      lcgsh_pkg::ST_DRAW_READ: state_d = lcgsh_pkg::ST_DRAW_WAIT;
      lcgsh_pkg::ST_DRAW_WAIT: begin
        if (sts_i.res_valid && sts_i.res_sel == lcgsh_pkg::GEN_B) begin
          state_d = lcgsh_pkg::ST_DRAW_FIN;
        end
      end
      lcgsh_pkg::ST_DRAW_FIN: begin
        if (slot_free) begin
          state_d = lcgsh_pkg::ST_IDLE;
        end
      end
      default: state_d = lcgsh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      lcgsh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      lcgsh_pkg::ST_SEED_LOAD: begin
        cmd_o.seed_load = 1'b1;
        cnt_d           = CntW'(TABLE_SIZE + 7);
        seeded_d        = 1'b1;
      end
      lcgsh_pkg::ST_SEED_ISSUE: begin
        cmd_o.step_go  = 1'b1;
        cmd_o.step_sel = lcgsh_pkg::GEN_A;
      end
      lcgsh_pkg::ST_SEED_WAIT: begin
        if (sts_i.res_valid) begin
          cmd_o.seed_wr = (cnt_q < CntW'(TABLE_SIZE));
          cmd_o.last_ld = (cnt_q == '0);
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      lcgsh_pkg::ST_DRAW_A: begin
        cmd_o.step_go  = 1'b1;
        cmd_o.step_sel = lcgsh_pkg::GEN_A;
      end
      lcgsh_pkg::ST_DRAW_B: begin
        cmd_o.step_go  = 1'b1;
        cmd_o.step_sel = lcgsh_pkg::GEN_B;
      end
      lcgsh_pkg::ST_DRAW_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      lcgsh_pkg::ST_DRAW_WAIT: begin
        cmd_o.rd_en = 1'b0;
      end
      lcgsh_pkg::ST_DRAW_FIN: begin
        if (slot_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgsh_pkg::ST_IDLE;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seed_idx_o  = cnt_q[IdxW-1:0];

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcgsh_pkg::ST_IDLE |-> !sts_i.res_valid)
    else $error("Step unit still busy while idle.");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_SIZE + 7))
    else $error("Warm-up counter out of range.");

  a_draw_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcgsh_pkg::ST_DRAW_A |-> seeded_q)
    else $error("Draw started before the table was seeded.");

endmodule

FILE: src/combined_lcg_shuffle_random_unit.sv
// Top level of the combined LCG random unit with a Bays-Durham shuffle table.
// Depends on lcgsh_pkg and lcgsh_if; instantiates lcgsh_ctrl and lcgsh_datapath.
//
//   channel  dir  word                 handshake
//   req_i    in   reseed               valid / ready, ready only while idle
//   rsp_o    out  value (31 bits)      valid / ready, registered
//   cfg_i    in   data = seed          valid / ready, ready always high
//
// In an ordinary draw, a new request is taken only once the last word is done: the result
// word becomes valid in the same cycle that the request side is ready again. Both generators
// share one Schrage step unit.
// Seeding (first request after reset, or reseed) adds a warm-up before the draw:
// the warm-up steps form one dependent chain through that unit.
// The result word waits in an output register; a stalled result delays only
// the final cycle of the next draw. No clearing pass follows reset.
module combined_lcg_shuffle_random_unit #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  lcgsh_req_if.sink     req_i,
  lcgsh_rsp_if.source   rsp_o,
  lcgsh_cfg_if.sink     cfg_i
);

  lcgsh_pkg::cmd_t               cmd;
  lcgsh_pkg::sts_t               sts;
  logic [$clog2(TABLE_SIZE)-1:0] seed_idx;

  assign cfg_i.ready = 1'b1;

  lcgsh_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .reseed_i    (req_i.reseed),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .seed_idx_o  (seed_idx)
  );

  lcgsh_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .cmd_i      (cmd),
    .seed_idx_i (seed_idx),
    .sts_o      (sts),
    .value_o    (rsp_o.value)
  );

endmodule
